// File: rtl/rpsd_pkg.sv
// ----------------------------------------------------------------------------
// rpsd_pkg: shared types and constants of the span decoder
// Holds field widths, register indexes, the sequencer states, the span step
// result type and the palette lookup.
// ----------------------------------------------------------------------------
package rpsd_pkg;

  localparam int CODE_W   = 8;
  localparam int IDX_W    = 7;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 11;
  localparam int ORG_W    = 10;
  localparam int DIM_W    = 11;
  localparam int CNT_W    = 7;
  localparam int COORD_W  = 11;
  localparam int LEN_W    = 11;
  localparam int COLOUR_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [DIM_W-1:0] MAX_DIM     = 11'd1024;
  localparam logic [DIM_W-1:0] MIN_WIDTH   = 11'd2;
  localparam logic [DIM_W-1:0] MIN_HEIGHT  = 11'd1;
  localparam logic [IDX_W-1:0] DEFINED_COLOURS = 7'd9;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rpsd_state_t;

  // Result of one span step of the shared unit.
  typedef struct packed {
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic [LEN_W-1:0]   len;
    logic [COL_W-1:0]   col_nxt;
    logic [ROW_W-1:0]   row_nxt;
    logic [CNT_W-1:0]   count_nxt;
    logic               last;
    logic               img_done;
  } span_step_t;

  // Opaque ARGB colour of a palette index; undefined indexes are black.
  function automatic logic [COLOUR_W-1:0] palette_colour(input logic [IDX_W-1:0] idx);
    logic [23:0] rgb;
    case (idx)
      7'd0:    rgb = 24'h000000;
      7'd1:    rgb = 24'h0000ff;
      7'd2:    rgb = 24'hff0000;
      7'd3:    rgb = 24'hff00ff;
      7'd4:    rgb = 24'h00ff00;
      7'd5:    rgb = 24'h00ffff;
      7'd6:    rgb = 24'hffff00;
      7'd7:    rgb = 24'hffffff;
      7'd8:    rgb = 24'h606060;
      default: rgb = 24'h000000;
    endcase
    return {8'hff, rgb};
  endfunction

endpackage

// File: rtl/rpsd_in_if.sv
// ----------------------------------------------------------------------------
// rpsd_in_if: code byte channel
// Valid/ready channel that carries one code byte per transaction.
// ----------------------------------------------------------------------------
interface rpsd_in_if
  import rpsd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

// File: rtl/rpsd_out_if.sv
// ----------------------------------------------------------------------------
// rpsd_out_if: span channel
// Valid/ready channel that carries one horizontal span per transaction.
// ----------------------------------------------------------------------------
interface rpsd_out_if
  import rpsd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  span_x;
  logic [COORD_W-1:0]  span_y;
  logic [LEN_W-1:0]    span_length;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_span;
  logic                image_done;
  logic                bad_index;

  modport source (output valid, output span_x, output span_y, output span_length,
                  output pixel_colour, output last_span, output image_done,
                  output bad_index, input ready);
  modport sink   (input valid, input span_x, input span_y, input span_length,
                  input pixel_colour, input last_span, input image_done,
                  input bad_index, output ready);
endinterface

// File: rtl/rpsd_span_unit.sv
// ----------------------------------------------------------------------------
// rpsd_span_unit: one span step
// Cuts the next span from the remaining run at the row end and advances the
// drawing position. Used once per cycle by the sequencer in the top level while its output register can take a span.
// ----------------------------------------------------------------------------
module rpsd_span_unit
  import rpsd_pkg::*;
(
  input  logic [CNT_W-1:0] count,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic [DIM_W-1:0] width,
  input  logic [DIM_W-1:0] height,
  input  logic [ORG_W-1:0] origin_x,
  input  logic [ORG_W-1:0] origin_y,
  output span_step_t       step
);

  logic [DIM_W-1:0] room;
  logic [LEN_W-1:0] count_ext;
  logic [LEN_W-1:0] len;
  logic [DIM_W-1:0] col_sum;
  logic             wrap;
  logic [ROW_W-1:0] row_inc;

  always_comb begin
    room      = width - DIM_W'(col);
    count_ext = LEN_W'(count);
    len       = (count_ext < room) ? count_ext : room;
    col_sum   = DIM_W'(col) + len;
    wrap      = (col_sum >= width);
    row_inc   = row + ROW_W'(wrap);

    step.span_x    = COORD_W'(origin_x) + COORD_W'(col);
    step.span_y    = COORD_W'(origin_y) + row;
    step.len       = len;
    step.col_nxt   = wrap ? '0 : col_sum[COL_W-1:0];
    step.row_nxt   = row_inc;
    step.count_nxt = count - len[CNT_W-1:0];
    step.img_done  = wrap && (row_inc >= height);
    step.last      = (step.count_nxt == '0) || step.img_done;
  end

endmodule

// File: rtl/rle_palette_bitmap_span_decoder_top.sv
// ----------------------------------------------------------------------------
// rle_palette_bitmap_span_decoder_top: run-length palette span decoder
// Turns code bytes into horizontal pixel spans of a placed image.
// ----------------------------------------------------------------------------
// Usage:
// Code bytes arrive on in_ch, one per transaction. A byte below 0x80 selects
// a palette index and draws one pixel; a larger byte repeats the current
// colour (byte - 0x80) times. Spans leave on out_ch, one per transaction,
// split at every row end; the final span of a byte carries last_span and the
// span that finishes the last row carries image_done.
// A byte is taken while the sequencer is idle; its spans, N of them with N
// from 0 to 64, then pass one at a time through the shared span unit. The span output
// register is loaded only when it is empty or being drained, so a stall on
// out_ch holds the sequencer on the current span; in_ch stays not ready
// until every span of the byte is in the output register.
// Bytes with no result (a zero run, or any byte once the image is done) are
// taken without leaving the idle state. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while idle, which the block does not enforce;
// every write restarts the image at its top-left pixel.
// Reset (rst_n low at a clock edge) restores origin 0,0, a 64 by 64 image,
// palette index 0 and the top-left position, and empties the output register.
// ----------------------------------------------------------------------------
module rle_palette_bitmap_span_decoder_top
  import rpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rpsd_in_if.sink               in_ch,
  rpsd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [ORG_W-1:0] origin_x_r, origin_y_r;
  logic [DIM_W-1:0] image_width_r, image_height_r;

  // Drawing state and the run being emitted.
  rpsd_state_t      st_r, st_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  span_x_r, span_y_r;
  logic [LEN_W-1:0]    span_len_r;
  logic [COLOUR_W-1:0] colour_r;
  logic                last_r, done_r, bad_r;

  logic [DIM_W-1:0] width_eff, height_eff;
  logic             accept;
  logic             load;
  span_step_t       step;

  // Out-of-range dimensions are clamped to the supported range.
  always_comb begin
    if (image_width_r < MIN_WIDTH) begin
      width_eff = MIN_WIDTH;
    end else if (image_width_r > MAX_DIM) begin
      width_eff = MAX_DIM;
    end else begin
      width_eff = image_width_r;
    end
    if (image_height_r < MIN_HEIGHT) begin
      height_eff = MIN_HEIGHT;
    end else if (image_height_r > MAX_DIM) begin
      height_eff = MAX_DIM;
    end else begin
      height_eff = image_height_r;
    end
  end

  rpsd_span_unit u_span (
    .count    (cnt_r),
    .col      (col_r),
    .row      (row_r),
    .width    (width_eff),
    .height   (height_eff),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .step     (step)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // A span is produced when the output register is free or drains this cycle.
  assign load        = (st_r == ST_RUN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt      = st_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cur_idx_nxt = cur_idx_r;
    cnt_nxt     = cnt_r;
    case (st_r)
      ST_IDLE: begin
        // Once the last row is complete, bytes are dropped without effect.
        if (accept && (row_r < height_eff)) begin
          if (!in_ch.code_byte[CODE_W-1]) begin
            cur_idx_nxt = in_ch.code_byte[IDX_W-1:0];
            cnt_nxt     = CNT_W'(1);
            st_nxt      = ST_RUN;
          end else begin
            cnt_nxt = in_ch.code_byte[CNT_W-1:0];
            if (in_ch.code_byte[CNT_W-1:0] != '0) begin
              st_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (load) begin
          col_nxt = step.col_nxt;
          row_nxt = step.row_nxt;
          cnt_nxt = step.count_nxt;
          if (step.last) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    // Any configuration write restarts the image; the user must write only while idle, as nothing here enforces it.
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      cur_idx_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cur_idx_r   <= cur_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      image_width_r  <= DIM_W'(64);
      image_height_r <= DIM_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:     origin_x_r     <= cfg_wdata[ORG_W-1:0];
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata[ORG_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Span payload; the palette index is fixed for the whole run.
  always_ff @(posedge clk) begin
    if (load) begin
      span_x_r   <= step.span_x;
      span_y_r   <= step.span_y;
      span_len_r <= step.len;
      colour_r   <= palette_colour(cur_idx_r);
      last_r     <= step.last;
      done_r     <= step.img_done;
      bad_r      <= (cur_idx_r >= DEFINED_COLOURS);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.span_x       = span_x_r;
  assign out_ch.span_y       = span_y_r;
  assign out_ch.span_length  = span_len_r;
  assign out_ch.pixel_colour = colour_r;
  assign out_ch.last_span    = last_r;
  assign out_ch.image_done   = done_r;
  assign out_ch.bad_index    = bad_r;

endmodule
